// File: rtl/decimal_field_frame_serializer_top_macros.svh
// Assertion macros used by the serializer's back module (dffs_back).
// Both expect signals named clock and reset in the scope where they are used.
`ifndef DECIMAL_FIELD_FRAME_SERIALIZER_TOP_MACROS_SVH
`define DECIMAL_FIELD_FRAME_SERIALIZER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DFFS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition in one cycle that forces another condition in the next cycle.
`define DFFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dffs_pkg.sv
package dffs_pkg;

   typedef struct packed {
      logic [7:0]  command_letter;
      logic [13:0] user_id;
      logic [6:0]  group_id;
      logic [9:0]  device_id;
      logic [7:0]  action_byte;
      logic [19:0] reply_delay;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   // One converted frame. Element 0 of each digit vector is the least
   // significant digit.
   typedef struct packed {
      logic [7:0]      command;
      logic [7:0]      action;
      logic [3:0][3:0] user_dig;
      logic [1:0][3:0] group_dig;
      logic [2:0][3:0] device_dig;
      logic [5:0][3:0] delay_dig;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic [19:0] q;
      logic [3:0]  r;
   } div10_type;

   localparam logic [13:0] USER_MAX   = 14'd9999;
   localparam logic [6:0]  GROUP_MAX  = 7'd99;
   localparam logic [9:0]  DEVICE_MAX = 10'd999;
   localparam logic [19:0] DELAY_MAX  = 20'd999999;

   localparam logic [2:0] USER_DIGITS   = 3'd4;
   localparam logic [2:0] GROUP_DIGITS  = 3'd2;
   localparam logic [2:0] DEVICE_DIGITS = 3'd3;
   localparam logic [2:0] DELAY_DIGITS  = 3'd6;

   localparam logic [7:0] CHAR_AT   = 8'h40;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   localparam logic [4:0] POS_START  = 5'd0;
   localparam logic [4:0] POS_CMD    = 5'd1;
   localparam logic [4:0] POS_ACTION = 5'd11;
   localparam logic [4:0] POS_HASH   = 5'd18;
   localparam logic [4:0] POS_LF     = 5'd19;
   localparam logic [4:0] POS_LAST   = 5'd20;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Quotient and remainder by ten through a reciprocal multiply; the
   // quotient is exact for every value below 2**22.
   function automatic div10_type div10(input logic [19:0] v);
      logic [42:0] prod;
      logic [19:0] q;
      logic [19:0] rem;
      div10_type   res;
      prod = {23'd0, v} * 43'd838861;
      q = prod[42:23];
      rem = v - {q[16:0], 3'b000} - {q[18:0], 1'b0};
      res.q = q;
      res.r = rem[3:0];
      return res;
   endfunction

endpackage

// File: rtl/decimal_field_frame_serializer_top.sv
// Turns each request word into a 21-byte ASCII frame, one byte per result
// word, with last_byte set on the closing CR. The front converts the four
// numeric fields to zero-padded decimal (saturating to all nines) with one
// divide-by-ten step per digit in each field, and takes a new request only
// after it has pushed the previous frame into the two-frame queue. The back
// sends one byte per cycle from the queue while pop is held high and frames
// are waiting, so the single byte output sets the sustained request rate.
module decimal_field_frame_serializer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  dffs_pkg::req_type req_word,
   output logic              empty,
   input  logic              pop,
   output dffs_pkg::rsp_type rsp_word
);
   import dffs_pkg::*;

   fifo_status_type q_status;
   frame_type       front_frame;
   frame_type       queue_frame;
   logic            q_push;
   logic            q_pop;

   dffs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .q_status (q_status),
      .q_push   (q_push),
      .q_frame  (front_frame)
   );

   dffs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (front_frame),
      .pop        (q_pop),
      .pop_frame  (queue_frame),
      .status     (q_status)
   );

   dffs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_frame  (queue_frame),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

endmodule

// File: rtl/dffs_front.sv
module dffs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  dffs_pkg::req_type         req_word,
   input  dffs_pkg::fifo_status_type q_status,
   output logic                      q_push,
   output dffs_pkg::frame_type       q_frame
);
   import dffs_pkg::*;

   typedef enum logic [1:0] {IDLE, CONV, DONE} state_type;

   state_type   state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [13:0] user_ff, user_in;
   logic [6:0]  group_ff, group_in;
   logic [9:0]  device_ff, device_in;
   logic [19:0] delay_ff, delay_in;
   frame_type   frame_ff, frame_in;
   div10_type   du, dg, dd, dl;

   always_comb begin
      du = div10({6'd0, user_ff});
      dg = div10({13'd0, group_ff});
      dd = div10({10'd0, device_ff});
      dl = div10(delay_ff);

      state_in  = state_ff;
      step_in   = step_ff;
      user_in   = user_ff;
      group_in  = group_ff;
      device_in = device_ff;
      delay_in  = delay_ff;
      frame_in  = frame_ff;

      case (state_ff)
         IDLE: begin
            if (push) begin
               frame_in.command = req_word.command_letter;
               frame_in.action  = req_word.action_byte;
               user_in   = (req_word.user_id > USER_MAX) ? USER_MAX : req_word.user_id;
               group_in  = (req_word.group_id > GROUP_MAX) ? GROUP_MAX : req_word.group_id;
               device_in = (req_word.device_id > DEVICE_MAX) ? DEVICE_MAX
                                                             : req_word.device_id;
               delay_in  = (req_word.reply_delay > DELAY_MAX) ? DELAY_MAX
                                                              : req_word.reply_delay;
               step_in   = 3'd0;
               state_in  = CONV;
            end
         end
         CONV: begin
            // Each lane peels off its low digit; the shorter lanes stop once they
            // have all their digits so they are not pushed out of the vector.
            if (step_ff < USER_DIGITS) begin
               user_in = du.q[13:0];
               frame_in.user_dig = {du.r, frame_ff.user_dig[3:1]};
            end
            if (step_ff < GROUP_DIGITS) begin
               group_in = dg.q[6:0];
               frame_in.group_dig = {dg.r, frame_ff.group_dig[1]};
            end
            if (step_ff < DEVICE_DIGITS) begin
               device_in = dd.q[9:0];
               frame_in.device_dig = {dd.r, frame_ff.device_dig[2:1]};
            end
            delay_in = dl.q;
            frame_in.delay_dig = {dl.r, frame_ff.delay_dig[5:1]};
            step_in = step_ff + 3'd1;
            if (step_ff == DELAY_DIGITS - 3'd1) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (!q_status.full) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      user_ff   <= user_in;
      group_ff  <= group_in;
      device_ff <= device_in;
      delay_ff  <= delay_in;
      frame_ff  <= frame_in;
   end

   assign full    = (state_ff != IDLE);
   assign q_push  = (state_ff == DONE) && !q_status.full;
   assign q_frame = frame_ff;

endmodule

// File: rtl/dffs_fifo.sv
module dffs_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dffs_pkg::frame_type       push_frame,
   input  logic                      pop,
   output dffs_pkg::frame_type       pop_frame,
   output dffs_pkg::fifo_status_type status
);
   import dffs_pkg::*;

   frame_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign pop_frame    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: rtl/dffs_back.sv
`include "decimal_field_frame_serializer_top_macros.svh"

module dffs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dffs_pkg::fifo_status_type q_status,
   input  dffs_pkg::frame_type       q_frame,
   output logic                      q_pop,
   input  logic                      pop,
   output logic                      empty,
   output dffs_pkg::rsp_type         rsp_word
);
   import dffs_pkg::*;

   // Subtracting the position from these gives the digit's place in the
   // packed digit vector, which holds the user id's top digit at the left.
   localparam logic [4:0] NUM_HI_TOP = 5'd16;
   localparam logic [4:0] NUM_LO_TOP = 5'd17;

   logic            have_ff, have_in;
   logic [4:0]      pos_ff, pos_in;
   frame_type       frame_ff, frame_in;
   rsp_type         out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   logic [14:0][3:0] digits;
   logic [4:0]      dig_idx;
   logic [7:0]      cur_byte;
   logic            out_load;
   logic            frame_end;
   logic            take;

   always_comb begin
      digits = {frame_ff.user_dig, frame_ff.group_dig, frame_ff.device_dig,
                frame_ff.delay_dig};
      dig_idx = 5'd0;
      if (pos_ff == POS_START) begin
         cur_byte = CHAR_AT;
      end else if (pos_ff == POS_CMD) begin
         cur_byte = frame_ff.command;
      end else if (pos_ff < POS_ACTION) begin
         dig_idx = NUM_HI_TOP - pos_ff;
         cur_byte = CHAR_ZERO + {4'd0, digits[dig_idx[3:0]]};
      end else if (pos_ff == POS_ACTION) begin
         cur_byte = frame_ff.action;
      end else if (pos_ff < POS_HASH) begin
         dig_idx = NUM_LO_TOP - pos_ff;
         cur_byte = CHAR_ZERO + {4'd0, digits[dig_idx[3:0]]};
      end else if (pos_ff == POS_HASH) begin
         cur_byte = CHAR_HASH;
      end else if (pos_ff == POS_LF) begin
         cur_byte = CHAR_LF;
      end else begin
         cur_byte = CHAR_CR;
      end

      // While a frame is held, a byte moves into the output register when
      // it is free or being emptied, so steady pops drain one byte per cycle.
      out_load  = have_ff && (!out_valid_ff || pop);
      frame_end = out_load && (pos_ff == POS_LAST);
      take      = (!have_ff || frame_end) && !q_status.empty;

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      pos_in       = pos_ff;
      if (out_load) begin
         out_in.tx_byte   = cur_byte;
         out_in.last_byte = (pos_ff == POS_LAST);
         out_valid_in     = 1'b1;
         pos_in           = frame_end ? POS_START : pos_ff + 5'd1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      have_in = have_ff;
      if (take) begin
         have_in = 1'b1;
      end else if (frame_end) begin
         have_in = 1'b0;
      end
      frame_in = take ? q_frame : frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         pos_ff       <= POS_START;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      frame_ff <= frame_in;
      out_ff   <= out_in;
   end

   assign q_pop    = take;
   assign empty    = !out_valid_ff;
   assign rsp_word = out_ff;

   `DFFS_ASSERT_ALWAYS(a_pos_range, pos_ff <= POS_LAST, "byte position beyond the frame")
   `DFFS_ASSERT_ALWAYS(a_idle_pos, !have_ff |-> pos_ff == POS_START, "idle with open frame")
   `DFFS_ASSERT_NEXT(a_last_flag, frame_end, out_valid_ff && out_ff.last_byte, "CR not flagged")
   `DFFS_ASSERT_NEXT(a_no_early_last, out_load && pos_ff != POS_LAST, !out_ff.last_byte,
                     "last flag before the CR")

endmodule

// File: tb/tb_decimal_field_frame_serializer_top.sv
`timescale 1ns / 100ps

module tb_decimal_field_frame_serializer_top;
   import dffs_pkg::*;

   localparam int FRAME_BYTES      = 21;
   localparam int RANDOM_REQUESTS  = 480;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_AT_WORD     = 21 * 60;
   localparam int MAX_PRINTED      = 40;

   typedef struct {
      req_type word;
      bit      drain_first;
   } pending_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_word = '0;
   rsp_type rsp_word;

   pending_type pending_q[$];
   rsp_type     frame_bytes_due[$];

   int errors = 0;
   int requests_sent = 0;
   int total_requests = 0;
   int bytes_checked = 0;
   int saturated_fields = 0;
   int full_stall_cycles = 0;
   int tx_wait = 0;
   int tx_calm = 0;
   int rx_wait = 0;
   int rx_calm = 0;

   decimal_field_frame_serializer_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_decimal_field_frame_serializer_top NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
         $display("MISMATCH @%0t: %s", $time, what);
      end
   endtask

   // Character of one decimal place (0 is the units) of a value saturated to its ceiling.
   function automatic logic [7:0] decimal_char(input int unsigned value,
                                               input int unsigned ceiling,
                                               input int place);
      int unsigned v;
      v = (value > ceiling) ? ceiling : value;
      repeat (place) v = v / 10;
      return CHAR_ZERO + 8'(v % 10);
   endfunction

   function automatic void queue_frame_bytes(input req_type r);
      logic [7:0] text [FRAME_BYTES];
      rsp_type    b;
      int         k;
      text[POS_START]  = CHAR_AT;
      text[POS_CMD]    = r.command_letter;
      text[POS_ACTION] = r.action_byte;
      text[POS_HASH]   = CHAR_HASH;
      text[POS_LF]     = CHAR_LF;
      text[POS_LAST]   = CHAR_CR;
      for (k = 0; k < 4; k++) text[5 - k] = decimal_char(r.user_id, USER_MAX, k);
      for (k = 0; k < 2; k++) text[7 - k] = decimal_char(r.group_id, GROUP_MAX, k);
      for (k = 0; k < 3; k++) text[10 - k] = decimal_char(r.device_id, DEVICE_MAX, k);
      for (k = 0; k < 6; k++) text[17 - k] = decimal_char(r.reply_delay, DELAY_MAX, k);
      for (k = 0; k < FRAME_BYTES; k++) begin
         b.tx_byte = text[k];
         b.last_byte = (k == POS_LAST);
         frame_bytes_due.push_back(b);
      end
   endfunction

   task automatic add_request(input int unsigned cmd, input int unsigned user,
                              input int unsigned group, input int unsigned device,
                              input int unsigned action, input int unsigned delay,
                              input bit drain_first);
      pending_type p;
      p.word.command_letter = 8'(cmd);
      p.word.user_id = 14'(user);
      p.word.group_id = 7'(group);
      p.word.device_id = 10'(device);
      p.word.action_byte = 8'(action);
      p.word.reply_delay = 20'(delay);
      p.drain_first = drain_first;
      pending_q.push_back(p);
   endtask

   // Mostly in range, with a share of small values, values around the limit
   // and values past it up to the top of the field.
   function automatic int unsigned pick_value(input int unsigned limit, input int unsigned top);
      case ($urandom_range(0, 9))
         0: return $urandom_range(limit + 1, top);
         1: return $urandom_range(limit - 2, limit + 2);
         2: return $urandom_range(0, 9);
         default: return $urandom_range(0, limit);
      endcase
   endfunction

   // Sender: one request word at a time from the pending queue.
   always @(posedge clock) begin
      pending_type nxt;
      if (reset) begin
         push <= 1'b0;
         tx_wait = 0;
      end else begin
         if (push && full) begin
            full_stall_cycles++;
         end
         if (push && !full) begin
            queue_frame_bytes(req_word);
            requests_sent++;
            saturated_fields += (req_word.user_id > USER_MAX) + (req_word.group_id > GROUP_MAX)
                              + (req_word.device_id > DEVICE_MAX)
                              + (req_word.reply_delay > DELAY_MAX);
            if (tx_calm != 0) begin
               tx_calm--;
               tx_wait = 0;
            end else begin
               tx_wait = $urandom_range(0, 19);
               if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(10, 30);
            end
         end
         if (!(push && full)) begin
            if (tx_wait != 0) begin
               tx_wait--;
               push <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         (!pending_q[0].drain_first || frame_bytes_due.size() == 0)) begin
               nxt = pending_q.pop_front();
               req_word <= nxt.word;
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted result word against the oldest expected byte.
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         pop <= 1'b0;
         rx_wait = 0;
      end else if (pop && !empty) begin
         bytes_checked++;
         if (frame_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word tx_byte=%02h last_byte=%0b",
                                      rsp_word.tx_byte, rsp_word.last_byte));
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_word.tx_byte !== due.tx_byte) begin
               report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                         rsp_word.tx_byte, due.tx_byte));
            end
            if (rsp_word.last_byte !== due.last_byte) begin
               report_mismatch($sformatf("last_byte %0b, expected %0b",
                                         rsp_word.last_byte, due.last_byte));
            end
         end
         if (bytes_checked == HOLD_AT_WORD) begin
            rx_wait = LONG_HOLD_CYCLES;
         end else if (rx_calm != 0) begin
            rx_calm--;
            rx_wait = 0;
         end else begin
            rx_wait = $urandom_range(0, 19);
            if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(40, 120);
         end
         if (rx_wait != 0) begin
            pop <= 1'b0;
         end
      end else if (!pop) begin
         if (rx_wait != 0) begin
            rx_wait--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      int n;
      add_request(8'h00, 0, 0, 0, 8'h00, 0, 1'b0);
      add_request(8'hFF, 9999, 99, 999, 8'hFF, 999999, 1'b0);
      add_request(8'h41, 10000, 100, 1000, 8'h42, 1000000, 1'b0);
      add_request(8'h55, 16383, 127, 1023, 8'hAA, 1048575, 1'b0);
      add_request(8'h01, 1, 1, 1, 8'h01, 1, 1'b0);
      add_request(8'h53, 1234, 56, 789, 8'h52, 123456, 1'b0);
      add_request(8'h40, 9998, 98, 998, 8'h23, 999998, 1'b0);
      add_request(8'h0A, 1000, 10, 100, 8'h0D, 100000, 1'b0);
      add_request(8'h0D, 999, 9, 99, 8'h0A, 99999, 1'b0);
      add_request(8'h80, 8192, 64, 512, 8'h7F, 524288, 1'b0);
      add_request(8'h7F, 5000, 50, 500, 8'h80, 500000, 1'b1);
      add_request(8'h30, 12000, 42, 7, 8'h39, 314159, 1'b0);
      add_request(8'h39, 7, 120, 0, 8'h30, 0, 1'b0);
      add_request(8'h57, 10, 3, 1010, 8'h58, 2718, 1'b0);
      add_request(8'h23, 4321, 0, 321, 8'h40, 1000001, 1'b0);
      add_request(8'hAA, 10001, 101, 1001, 8'h55, 999999, 1'b0);
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         add_request($urandom_range(0, 255), pick_value(USER_MAX, 16383),
                     pick_value(GROUP_MAX, 127), pick_value(DEVICE_MAX, 1023),
                     $urandom_range(0, 255), pick_value(DELAY_MAX, 1048575),
                     n == RANDOM_REQUESTS / 2);
      end
      total_requests = pending_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (requests_sent != total_requests) @(posedge clock);
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d requests (%0d saturating fields), checked %0d frame bytes.",
               requests_sent, saturated_fields, bytes_checked);
      $display("Input held off by full for %0d cycles; %0d mismatches.",
               full_stall_cycles, errors);
      if (errors == 0) begin
         $display("tb_decimal_field_frame_serializer_top OK");
      end else begin
         $display("tb_decimal_field_frame_serializer_top NOT OK");
      end
      $finish;
   end

endmodule
